// ----- sv/baro_accel_altitude_filter_unit_defines.svh -----
// Assertion macros for the altitude filter checker.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef BARO_ACCEL_ALTITUDE_FILTER_UNIT_DEFINES_SVH
`define BARO_ACCEL_ALTITUDE_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define BAF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/baf_pkg.sv -----
// Shared types, constants and saturation helpers of the altitude filter.
// No dependencies; used by all modules of the block.
`timescale 1ns / 1ps
package baf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WFRAC         = 16;
    localparam int WEIGHT_W      = 24;
    localparam int NUM_CFG       = 3;
    localparam int IN_TDATA_W    = 168;
    localparam int IN_TUSER_W    = 4;
    localparam int OUT_TDATA_W   = 96;
    localparam int DSR_W         = 20;
    localparam int STEP_W        = 6;

    localparam logic [WEIGHT_W-1:0] BARO_W_RST  = 24'd32768;
    localparam logic [WEIGHT_W-1:0] ACCEL_W_RST = 24'd1310720;
    localparam logic [WEIGHT_W-1:0] BIAS_W_RST  = 24'd3277;

    localparam logic [1:0] CFG_BARO_W  = 2'd0;
    localparam logic [1:0] CFG_ACCEL_W = 2'd1;
    localparam logic [1:0] CFG_BIAS_W  = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [DSR_W-1:0] US_PER_S  = 20'd1000000;
    localparam logic [DSR_W-1:0] DIV_THREE = 20'd3;

    localparam logic signed [35:0] MAX36 = 36'sd2147483647;
    localparam logic signed [35:0] MIN36 = -36'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DT,
        ST_RUN,
        ST_MUL,
        ST_DIV3
    } fsm_state_t;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_ACC,
        MS_NEG,
        MS_RND
    } mul_state_t;

    typedef struct packed {
        logic start;
        logic wmode;   // 1: data by weight, scale back by WFRAC
    } mul_ctl_t;

    function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
        return {{4{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        if (v > MAX36)
            return 32'sh7FFFFFFF;
        else if (v < MIN36)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ----- sv/baf_mul.sv -----
// Bit-serial signed multiplier with round-to-nearest scaling and saturation.
// Depends on baf_pkg.
`timescale 1ns / 1ps
module baf_mul
    import baf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mul_ctl_t            ctl,
    input  logic signed [31:0]  a,
    input  logic signed [32:0]  b,
    output logic                done,
    output logic signed [31:0]  result
);

    mul_state_t         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        ma_reg, ma_next;
    logic [31:0]        mb_reg, mb_next;
    logic [63:0]        p_reg, p_next;
    logic               neg_reg, neg_next;
    logic               wide_reg, wide_next;
    logic signed [64:0] ps_reg, ps_next;
    logic signed [31:0] res_reg, res_next;
    logic               done_reg, done_next;

    logic [32:0]        sum33;
    logic [32:0]        bmag;
    logic [4:0]         shamt;
    logic signed [64:0] rnd;
    logic signed [64:0] sh;

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        p_reg    <= p_next;
        neg_reg  <= neg_next;
        wide_reg <= wide_next;
        ps_reg   <= ps_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        p_next     = p_reg;
        neg_next   = neg_reg;
        wide_next  = wide_reg;
        ps_next    = ps_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        bmag       = b[32] ? 33'(-b) : b;
        sum33      = {1'b0, p_reg[63:32]} + (mb_reg[0] ? {1'b0, ma_reg} : 33'd0);
        shamt      = wide_reg ? 5'(WFRAC) : 5'(FRAC_BITS);
        rnd        = ps_reg + (65'sd1 <<< (shamt - 5'd1));
        sh         = rnd >>> shamt;
        case (state_reg)
            MS_IDLE:
            begin
                if (ctl.start)
                begin
                    ma_next    = a[31] ? 32'(-a) : a;
                    mb_next    = bmag[31:0];
                    neg_next   = a[31] ^ b[32];
                    wide_next  = ctl.wmode;
                    p_next     = '0;
                    cnt_next   = '0;
                    state_next = MS_ACC;
                end
            end
            MS_ACC:
            begin
                // add the multiplicand under the current multiplier bit, then shift
                p_next   = {sum33, p_reg[31:1]};
                mb_next  = {1'b0, mb_reg[31:1]};
                cnt_next = cnt_reg + 5'd1;
                if (&cnt_reg)
                    state_next = MS_NEG;
            end
            MS_NEG:
            begin
                ps_next    = neg_reg ? -$signed({1'b0, p_reg}) : $signed({1'b0, p_reg});
                state_next = MS_RND;
            end
            MS_RND:
            begin
                if ((&sh[64:31]) || !(|sh[64:31]))
                    res_next = sh[31:0];
                else
                    res_next = sh[64] ? 32'sh80000000 : 32'sh7FFFFFFF;
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/baf_div.sv -----
// Bit-serial restoring divider for unsigned dividends by a narrow divisor.
// Depends on baf_pkg.
`timescale 1ns / 1ps
module baf_div
    import baf_pkg::*;
#(
    parameter int DVW = 49
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVW-1:0]   dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVW-1:0]   quotient
);

    localparam int CW = $clog2(DVW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DVW-1:0]   quo_reg, quo_next;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[DVW-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (busy_reg)
        begin
            // bring down one dividend bit, subtract when it fits
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DSR_W-1:0];
                quo_next = {quo_reg[DVW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DSR_W-1:0];
                quo_next = {quo_reg[DVW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DVW - 1);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
    end

endmodule

// ----- sv/baro_accel_altitude_filter_unit.sv -----
// Load item: taken while idle, no result. Step item with both sensors: 23 passes
// through the bit-serial multiplier, plus two passes through the serial divider
// (dt, div by 3). One item at a time; a finished result waits in the output
// register while the next item is taken. Asynchronous active-low reset clears
// filter state and restores default weights.
`timescale 1ns / 1ps
module baro_accel_altitude_filter_unit
    import baf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [WEIGHT_W-1:0]    cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row_index[1:0], value_a[33:2], value_b[65:34], value_c[97:66],
    // timestamp_us[129:98], baro_alt[161:130], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[0], sensors_ready[1], baro_valid[2], acc_valid[3]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // altitude_ned[31:0], vertical_speed[63:32], vertical_accel[95:64]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int DVW = 33 + FRAC_BITS;
    localparam logic [63:0] G_WIDE = ((64'd980665 << FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam logic signed [31:0] G_FIX = G_WIDE[31:0];

    fsm_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic signed [31:0]  est_reg [3];
    logic signed [31:0]  est_next [3];
    logic signed [31:0]  bias_reg [3];
    logic signed [31:0]  bias_next [3];
    logic signed [31:0]  rot_reg [3];
    logic signed [31:0]  rot_next [3];
    logic signed [31:0]  acc_reg [3];
    logic signed [31:0]  acc_next [3];
    logic signed [31:0]  berr_reg, berr_next;
    logic signed [31:0]  aerr_reg, aerr_next;
    logic [31:0]         last_reg, last_next;
    logic                tvld_reg, tvld_next;
    logic signed [31:0]  dt_reg, dt_next;
    logic signed [31:0]  x_reg, x_next;
    logic signed [31:0]  n_reg, n_next;
    logic signed [31:0]  cor_reg, cor_next;
    logic signed [31:0]  v2_reg, v2_next;
    logic signed [31:0]  h_reg, h_next;
    logic signed [31:0]  alt_reg, alt_next;
    logic                sr_reg, sr_next;
    logic                bv_reg, bv_next;
    logic                av_reg, av_next;
    logic                dneg_reg, dneg_next;
    logic [WEIGHT_W-1:0] bw_reg, aw_reg, biw_reg;
    logic                mval_reg, mval_next;
    logic [OUT_TDATA_W-1:0] mdat_reg, mdat_next;

    mul_ctl_t            mul_ctl;
    logic signed [31:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic                mul_done;
    logic signed [31:0]  mul_res;
    logic                div_start;
    logic [DVW-1:0]      div_dvd;
    logic [DSR_W-1:0]    div_dsr;
    logic                div_done;
    logic [DVW-1:0]      div_q;

    logic [1:0]          li;
    logic [STEP_W-1:0]   boff;
    logic [1:0]          bi;
    logic [31:0]         el;
    logic [31:0]         xmag;
    logic signed [31:0]  nneg;
    logic signed [32:0]  hsum;
    logic signed [31:0]  est2_fin;
    logic [1:0]          row;
    logic signed [31:0]  in_c;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdat_reg;

    baf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    baf_div #(.DVW(DVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                est_reg[i]  <= '0;
                bias_reg[i] <= '0;
                rot_reg[i]  <= '0;
            end
            berr_reg <= '0;
            aerr_reg <= '0;
            last_reg <= '0;
            tvld_reg <= 1'b0;
            mval_reg <= 1'b0;
            bw_reg   <= BARO_W_RST;
            aw_reg   <= ACCEL_W_RST;
            biw_reg  <= BIAS_W_RST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            est_reg   <= est_next;
            bias_reg  <= bias_next;
            rot_reg   <= rot_next;
            berr_reg  <= berr_next;
            aerr_reg  <= aerr_next;
            last_reg  <= last_next;
            tvld_reg  <= tvld_next;
            mval_reg  <= mval_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BARO_W:  bw_reg  <= cfg_data;
                    CFG_ACCEL_W: aw_reg  <= cfg_data;
                    CFG_BIAS_W:  biw_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        dt_reg   <= dt_next;
        x_reg    <= x_next;
        n_reg    <= n_next;
        cor_reg  <= cor_next;
        v2_reg   <= v2_next;
        h_reg    <= h_next;
        alt_reg  <= alt_next;
        sr_reg   <= sr_next;
        bv_reg   <= bv_next;
        av_reg   <= av_next;
        dneg_reg <= dneg_next;
        mdat_reg <= mdat_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        est_next   = est_reg;
        bias_next  = bias_reg;
        rot_next   = rot_reg;
        acc_next   = acc_reg;
        berr_next  = berr_reg;
        aerr_next  = aerr_reg;
        last_next  = last_reg;
        tvld_next  = tvld_reg;
        dt_next    = dt_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        cor_next   = cor_reg;
        v2_next    = v2_reg;
        h_next     = h_reg;
        alt_next   = alt_reg;
        sr_next    = sr_reg;
        bv_next    = bv_reg;
        av_next    = av_reg;
        dneg_next  = dneg_reg;
        mdat_next  = mdat_reg;
        mval_next  = mval_reg && !m_axis_tready;

        mul_ctl    = '0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dsr    = US_PER_S;

        li       = step_reg[2:1];
        boff     = step_reg - STEP_W'(11);
        bi       = boff[3:2];
        row      = s_axis_tdata[1:0];
        in_c     = s_axis_tdata[97:66];
        el       = s_axis_tdata[129:98] - last_reg;
        xmag     = x_reg[31] ? 32'(-x_reg) : x_reg;
        nneg     = sat36(-ext36(n_reg));
        hsum     = ($signed({x_reg[31], x_reg}) + 33'sd1) >>> 1;
        est2_fin = sat36(ext36(est_reg[2]) + ext36(x_reg));

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0] == OP_LOAD)
                    begin
                        if (row != 2'd3)
                            rot_next[row] = in_c;
                    end
                    else
                    begin
                        acc_next[0] = s_axis_tdata[33:2];
                        acc_next[1] = s_axis_tdata[65:34];
                        acc_next[2] = in_c;
                        alt_next    = s_axis_tdata[161:130];
                        sr_next     = s_axis_tuser[1];
                        bv_next     = s_axis_tuser[2];
                        av_next     = s_axis_tuser[3];
                        last_next   = s_axis_tdata[129:98];
                        tvld_next   = 1'b1;
                        step_next   = '0;
                        if (tvld_reg)
                        begin
                            div_start  = 1'b1;
                            div_dvd    = (DVW'(el) << FRAC_BITS) + DVW'(500000);
                            div_dsr    = US_PER_S;
                            state_next = ST_DT;
                        end
                        else
                        begin
                            dt_next    = '0;
                            state_next = s_axis_tuser[1] ? ST_RUN : ST_IDLE;
                        end
                    end
                end
            end
            ST_DT:
            begin
                if (div_done)
                begin
                    dt_next    = (|div_q[DVW-1:31]) ? 32'sh7FFFFFFF : div_q[31:0];
                    state_next = sr_reg ? ST_RUN : ST_IDLE;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    x_next     = mul_res;
                    state_next = ST_RUN;
                end
            end
            ST_DIV3:
            begin
                if (div_done)
                begin
                    x_next     = dneg_reg ? 32'(-div_q[31:0]) : div_q[31:0];
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                case (step_reg)
                    6'd0:
                    begin
                        if (bv_reg)
                            berr_next = sat36(-ext36(alt_reg) - ext36(est_reg[0]));
                        n_next    = '0;
                        step_next = av_reg ? 6'd1 : 6'd8;
                    end
                    6'd1, 6'd3, 6'd5:
                    begin
                        mul_ctl.start = 1'b1;
                        mul_a = rot_reg[li];
                        mul_b = 33'(sat36(ext36(acc_reg[li]) - ext36(bias_reg[li])));
                        state_next = ST_MUL;
                    end
                    6'd2, 6'd4, 6'd6:
                    begin
                        n_next = sat36(ext36(n_reg) + ext36(x_reg));
                    end
                    6'd7:
                    begin
                        aerr_next = sat36(ext36(nneg) + ext36(G_FIX) - ext36(est_reg[2]));
                    end
                    6'd8, 6'd28:
                    begin
                        mul_ctl = '{start: 1'b1, wmode: 1'b1};
                        mul_a = berr_reg;
                        mul_b = {9'd0, bw_reg};
                        state_next = ST_MUL;
                    end
                    6'd9:
                    begin
                        mul_ctl = '{start: 1'b1, wmode: 1'b1};
                        mul_a = x_reg;
                        mul_b = {9'd0, bw_reg};
                        state_next = ST_MUL;
                    end
                    6'd10:
                    begin
                        cor_next = sat36(-ext36(x_reg));
                    end
                    6'd11, 6'd15, 6'd19:
                    begin
                        mul_ctl.start = 1'b1;
                        mul_a = rot_reg[bi];
                        mul_b = 33'(cor_reg);
                        state_next = ST_MUL;
                    end
                    6'd12, 6'd16, 6'd20:
                    begin
                        mul_ctl = '{start: 1'b1, wmode: 1'b1};
                        mul_a = x_reg;
                        mul_b = {9'd0, biw_reg};
                        state_next = ST_MUL;
                    end
                    6'd13, 6'd17, 6'd21, 6'd29, 6'd34:
                    begin
                        mul_ctl.start = 1'b1;
                        mul_a = x_reg;
                        mul_b = 33'(dt_reg);
                        state_next = ST_MUL;
                    end
                    6'd14, 6'd18, 6'd22:
                    begin
                        bias_next[bi] = sat36(ext36(bias_reg[bi]) + ext36(x_reg));
                    end
                    6'd23:
                    begin
                        // the third bias term flips sign on every ready step
                        bias_next[2] = sat36(-ext36(bias_reg[2]));
                    end
                    6'd24:
                    begin
                        mul_ctl.start = 1'b1;
                        mul_a = est_reg[2];
                        mul_b = 33'(dt_reg);
                        state_next = ST_MUL;
                    end
                    6'd25:
                    begin
                        v2_next = x_reg;
                        mul_ctl.start = 1'b1;
                        mul_a = x_reg;
                        mul_b = 33'(dt_reg);
                        state_next = ST_MUL;
                    end
                    6'd26:
                    begin
                        h_next = hsum[31:0];
                        mul_ctl.start = 1'b1;
                        mul_a = est_reg[1];
                        mul_b = 33'(dt_reg);
                        state_next = ST_MUL;
                    end
                    6'd27:
                    begin
                        est_next[0] = sat36(ext36(est_reg[0]) + ext36(x_reg) + ext36(h_reg));
                        est_next[1] = sat36(ext36(est_reg[1]) + ext36(v2_reg));
                    end
                    6'd30:
                    begin
                        est_next[0] = sat36(ext36(est_reg[0]) + ext36(x_reg));
                        mul_ctl = '{start: 1'b1, wmode: 1'b1};
                        mul_a = x_reg;
                        mul_b = {9'd0, bw_reg};
                        state_next = ST_MUL;
                    end
                    6'd31:
                    begin
                        est_next[1] = sat36(ext36(est_reg[1]) + ext36(x_reg));
                        mul_ctl = '{start: 1'b1, wmode: 1'b1};
                        mul_a = x_reg;
                        mul_b = {9'd0, bw_reg};
                        state_next = ST_MUL;
                    end
                    6'd32:
                    begin
                        // divide by three on the magnitude, rounding to nearest
                        div_start  = 1'b1;
                        div_dvd    = DVW'({1'b0, xmag} + 33'd1);
                        div_dsr    = DIV_THREE;
                        dneg_next  = x_reg[31];
                        state_next = ST_DIV3;
                    end
                    6'd33:
                    begin
                        est_next[2] = est2_fin;
                        mul_ctl = '{start: 1'b1, wmode: 1'b1};
                        mul_a = aerr_reg;
                        mul_b = {9'd0, aw_reg};
                        state_next = ST_MUL;
                    end
                    6'd35:
                    begin
                        // hold until the output register is free
                        if (!mval_reg || m_axis_tready)
                        begin
                            est_next[2] = est2_fin;
                            mdat_next   = {est2_fin, est_reg[1], est_reg[0]};
                            mval_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            step_next = step_reg;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/baf_checker.sv -----
// Port-level checker for the altitude filter, bound to the top level.
// Depends on baf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "baro_accel_altitude_filter_unit_defines.svh"
module baf_checker
    import baf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic in_xact;
    assign in_xact = s_axis_tvalid && s_axis_tready;

    `BAF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `BAF_ASSERT_NEXT(a_load_quick, in_xact && (s_axis_tuser[0] == OP_LOAD), s_axis_tready && !$rose(m_axis_tvalid), "load transaction stalled input or made a result")
    `BAF_ASSERT_NEXT(a_not_ready, in_xact && (s_axis_tuser[0] == OP_STEP) && !s_axis_tuser[1], !$rose(m_axis_tvalid), "step without ready sensors made a result")

endmodule

bind baro_accel_altitude_filter_unit baf_checker u_baf_checker (.*);

// ----- tb/baro_accel_altitude_filter_unit_checker.sv -----
// Checker for the altitude filter: watches config, input and output streams,
// predicts each result and compares field by field. Depends on baf_pkg.
`timescale 1ns / 1ps
module baro_accel_altitude_filter_unit_checker
    import baf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [WEIGHT_W-1:0]    cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                     fail_count,
    output int                     estimates_pending,
    output int                     estimates_seen
);

    localparam int     FB  = FRAC_BITS_DEF;
    localparam longint G_Q = ((64'sd980665 <<< FB) + 64'sd50000) / 64'sd100000;

    typedef struct {
        int alt;
        int spd;
        int acc;
    } estimate_t;

    estimate_t            expected_estimates[$];
    int                   est[3];
    int                   bias[3];
    int                   rot[9];
    int                   baro_err;
    int                   acc_err;
    logic [31:0]          last_ts;
    logic                 ts_known;
    logic [WEIGHT_W-1:0]  w_baro;
    logic [WEIGHT_W-1:0]  w_acc;
    logic [WEIGHT_W-1:0]  w_bias;

    function automatic int sat(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    // round to nearest, ties up
    function automatic longint round_shift(input longint p, input int s);
        return (p + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic int mul_q(input int a, input int b);
        return sat(round_shift(longint'(a) * longint'(b), FB));
    endfunction

    function automatic int mul_w(input int a, input logic [WEIGHT_W-1:0] w);
        longint wl;
        wl = longint'({40'd0, w});
        return sat(round_shift(longint'(a) * wl, WFRAC));
    endfunction

    function automatic int third(input int v);
        longint x;
        x = v;
        if (x >= 0)
            return int'((x + 1) / 3);
        return int'(-((-x + 1) / 3));
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic advance_filter(input logic [IN_TDATA_W-1:0] d, input logic [IN_TUSER_W-1:0] u);
        int          v[3];
        int          dt;
        int          corr2;
        int          ewdt;
        int          c;
        int          h;
        int          v2;
        longint      n;
        logic [31:0] elapsed;
        logic [1:0]  row;
        estimate_t   e;
        row  = d[1:0];
        v[0] = d[33:2];
        v[1] = d[65:34];
        v[2] = d[97:66];
        dt   = 0;
        if (u[0] == OP_LOAD) begin
            if (row < 2'd3)
                for (int i = 0; i < 3; i++)
                    rot[row * 3 + i] = v[i];
            return;
        end
        if (ts_known) begin
            elapsed = d[129:98] - last_ts;
            dt = sat(((longint'({32'd0, elapsed}) <<< FB) + 500000) / 1000000);
        end
        last_ts  = d[129:98];
        ts_known = 1'b1;
        if (!u[1])
            return;
        if (u[2])
            baro_err = sat(-longint'($signed(d[161:130])) - longint'(est[0]));
        if (u[3]) begin
            n = 0;
            for (int i = 0; i < 3; i++)
                n = sat(n + mul_q(rot[i * 3 + 2], sat(longint'(v[i]) - longint'(bias[i]))));
            n = sat(-n);
            acc_err = sat(n + G_Q - longint'(est[2]));
        end
        corr2 = sat(-longint'(mul_w(mul_w(baro_err, w_baro), w_baro)));
        for (int i = 0; i < 3; i++) begin
            c = mul_q(rot[i * 3 + 2], corr2);
            bias[i] = sat(longint'(bias[i]) + mul_q(mul_w(c, w_bias), dt));
        end
        // third bias term flips sign every ready step
        bias[2] = sat(-longint'(bias[2]));
        v2 = mul_q(est[2], dt);
        h  = sat(round_shift(longint'(mul_q(v2, dt)), 1));
        est[0] = sat(longint'(est[0]) + mul_q(est[1], dt) + h);
        est[1] = sat(longint'(est[1]) + v2);
        ewdt   = mul_q(mul_w(baro_err, w_baro), dt);
        est[0] = sat(longint'(est[0]) + ewdt);
        est[1] = sat(longint'(est[1]) + mul_w(ewdt, w_baro));
        est[2] = sat(longint'(est[2]) + third(mul_w(mul_w(ewdt, w_baro), w_baro)));
        ewdt   = mul_q(mul_w(acc_err, w_acc), dt);
        est[2] = sat(longint'(est[2]) + ewdt);
        e.alt = est[0];
        e.spd = est[1];
        e.acc = est[2];
        expected_estimates.push_back(e);
    endtask

    initial
    begin
        fail_count = 0;
        estimates_seen = 0;
    end

    assign estimates_pending = expected_estimates.size();

    always @(posedge clk or negedge rst_n)
    begin
        estimate_t e;
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                est[i]  = 0;
                bias[i] = 0;
            end
            for (int i = 0; i < 9; i++)
                rot[i] = 0;
            baro_err = 0;
            acc_err  = 0;
            last_ts  = '0;
            ts_known = 1'b0;
            w_baro   = BARO_W_RST;
            w_acc    = ACCEL_W_RST;
            w_bias   = BIAS_W_RST;
            expected_estimates.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BARO_W:  w_baro = cfg_data;
                    CFG_ACCEL_W: w_acc  = cfg_data;
                    CFG_BIAS_W:  w_bias = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_filter(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                estimates_seen++;
                if (expected_estimates.size() == 0) begin
                    $display("[%0t] unexpected result transaction", $realtime);
                    fail_count++;
                end else begin
                    e = expected_estimates.pop_front();
                    if ($signed(m_axis_tdata[31:0]) != e.alt)
                        report("altitude_ned", m_axis_tdata[31:0], e.alt);
                    if ($signed(m_axis_tdata[63:32]) != e.spd)
                        report("vertical_speed", m_axis_tdata[63:32], e.spd);
                    if ($signed(m_axis_tdata[95:64]) != e.acc)
                        report("vertical_accel", m_axis_tdata[95:64], e.acc);
                end
            end
        end
    end

endmodule

// ----- tb/baro_accel_altitude_filter_unit_test.sv -----
// Testbench top for the altitude filter: clock, reset, stimulus and verdict.
// Depends on baf_pkg, the filter unit and its checker module.
`timescale 1ns / 1ps
module baro_accel_altitude_filter_unit_test;
    import baf_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         SETTLE     = 2500;
    localparam int         LONG_HOLD  = 4000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [WEIGHT_W-1:0]    cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int                     fail_count;
    int                     estimates_pending;
    int                     estimates_seen;
    int                     items_sent;
    logic                   quiet;
    logic                   hold_output;
    logic [31:0]            clock_us;

    baro_accel_altitude_filter_unit u_dut (.*);

    baro_accel_altitude_filter_unit_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #20ms;
        $display("baro_accel_altitude_filter_unit_test: FAIL");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_output) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_output = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send(input logic op, input logic [1:0] row, input int a, input int b,
                        input int c, input logic [31:0] ts, input logic rdy,
                        input logic bv, input int alt, input logic av);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {6'd0, alt, ts, c, b, a, row};
        s_axis_tuser  <= {av, bv, rdy, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (estimates_pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [WEIGHT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int wide_or_mild(input int mild);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 2 * mild) - mild;
    endfunction

    task automatic random_item();
        if ($urandom_range(0, 6) == 0) begin
            send(OP_LOAD, $urandom_range(0, 3), wide_or_mild(65536), wide_or_mild(65536),
                 wide_or_mild(65536), $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            if ($urandom_range(0, 19) == 0)
                clock_us = $urandom;
            else
                clock_us = clock_us + $urandom_range(2000, 20000);
            send(OP_STEP, $urandom, wide_or_mild(1300000), wide_or_mild(1300000),
                 wide_or_mild(1300000), clock_us, $urandom_range(0, 9) != 0, $urandom,
                 wide_or_mild(6553600), $urandom);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        quiet         = 1'b0;
        hold_output   = 1'b0;
        items_sent    = 0;
        clock_us      = 32'd1000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rotation rows, ignored row, first step, wrap and extremes
        send(OP_LOAD, 2'd0, 32'sd65536, 0, 32'sd6553, 0, 0, 0, 0, 0);
        send(OP_LOAD, 2'd1, 0, 32'sd65536, -32'sd6553, 0, 0, 0, 0, 0);
        send(OP_LOAD, 2'd2, 0, 0, -32'sd65536, 0, 0, 0, 0, 0);
        send(OP_LOAD, 2'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 1, 0, 1);
        send(OP_STEP, 0, 0, 0, -32'sd642252, 32'd1000, 1, 1, 32'sd65536, 1);
        send(OP_STEP, 0, 0, 0, 0, 32'd6000, 0, 1, 32'sd65536, 1);
        send(OP_STEP, 0, 100, -100, -32'sd642252, 32'd16000, 1, 1, 32'sd131072, 1);
        send(OP_STEP, 0, 0, 0, 0, 32'd26000, 1, 0, 0, 0);
        send(OP_STEP, 0, 0, 0, 0, 32'hFFFFFF00, 1, 1, 32'sd70000, 0);
        send(OP_STEP, 0, 5, 5, 5, 32'd5000, 1, 0, 0, 1);
        send(OP_STEP, 3, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd15000, 1, 1,
             32'h7FFFFFFF, 1);
        send(OP_STEP, 3, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'd25000, 1, 1,
             32'h80000000, 1);
        send(OP_STEP, 0, 0, 0, 0, 32'hFFFFFFFF, 1, 1, 0, 1);
        send(OP_STEP, 0, 0, 0, 0, 32'd0, 1, 1, -32'sd65536, 1);
        send(OP_LOAD, 2'd2, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
        send(OP_STEP, 0, 32'h7FFFFFFF, 0, 32'h80000000, 32'd20000, 1, 1, 0, 1);
        send(OP_STEP, 0, 0, 0, 0, 32'd40000, 1, 1, 32'sd655360, 1);
        drain();
        send(OP_LOAD, 2'd2, 32'sd3000, -32'sd2000, 32'sd65000, 0, 0, 0, 0, 0);

        // random phases across weight settings
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            case (phase)
                0: begin
                    write_reg(CFG_BARO_W, BARO_W_RST);
                    write_reg(CFG_ACCEL_W, ACCEL_W_RST);
                    write_reg(CFG_BIAS_W, BIAS_W_RST);
                end
                1: begin
                    write_reg(CFG_BARO_W, '0);
                    write_reg(CFG_ACCEL_W, '0);
                    write_reg(CFG_BIAS_W, '0);
                    write_reg(CFG_UNUSED, '1);
                end
                2: begin
                    write_reg(CFG_BARO_W, '1);
                    write_reg(CFG_ACCEL_W, '1);
                    write_reg(CFG_BIAS_W, '1);
                end
                default: begin
                    write_reg(CFG_BARO_W, $urandom_range(0, 98304));
                    write_reg(CFG_ACCEL_W, $urandom_range(0, 3000000));
                    write_reg(CFG_BIAS_W, $urandom_range(0, 20000));
                end
            endcase
            quiet = (phase == 3);
            // fill the block while the output side holds off
            if (phase == 0)
                hold_output = 1'b1;
            for (int k = 0; k < 80; k++)
                random_item();
        end
        quiet = 1'b0;
        drain();

        $display("covered %0d input transactions, %0d result transactions, 5 weight settings",
                 items_sent, estimates_seen);
        if (fail_count == 0)
            $display("baro_accel_altitude_filter_unit_test: PASS");
        else
            $display("baro_accel_altitude_filter_unit_test: FAIL");
        $finish;
    end

endmodule
